// ===== design/cshs_pkg.sv =====
// Shared types and constants for the closest segment hit scan block.
package cshs_pkg;

    localparam int CoordBits = 16;
    localparam int IndexBits = 10;
    localparam int MaxWalls  = 1024;
    localparam int DiffBits  = CoordBits + 1;
    localparam int ProdBits  = 2 * DiffBits;
    localparam int DetBits   = ProdBits + 1;
    localparam int DistBits  = 2 * CoordBits + 2;
    localparam int QBits     = CoordBits + 2;
    localparam int QueueDepth = 4;
    localparam int QPtrBits  = 2;

    localparam logic [2:0] RegLookStartX = 3'd0;
    localparam logic [2:0] RegLookStartY = 3'd1;
    localparam logic [2:0] RegLookEndX   = 3'd2;
    localparam logic [2:0] RegLookEndY   = 3'd3;
    localparam logic [2:0] RegRefX       = 3'd4;
    localparam logic [2:0] RegRefY       = 3'd5;

    typedef logic signed [CoordBits-1:0] coord_t;

    typedef struct packed {
        coord_t wall_start_x;
        coord_t wall_start_y;
        coord_t wall_end_x;
        coord_t wall_end_y;
        logic   last_wall;
    } wall_t;

    typedef struct packed {
        logic   found;
        logic [IndexBits-1:0] hit_index;
        coord_t hit_x;
        coord_t hit_y;
    } result_t;

    typedef struct packed {
        coord_t look_start_x;
        coord_t look_start_y;
        coord_t look_end_x;
        coord_t look_end_y;
        coord_t ref_x;
        coord_t ref_y;
    } cfg_t;

    // Classified work passed from front to back.
    typedef struct packed {
        logic                 hit;
        logic                 last;
        logic [IndexBits-1:0] pos;
        logic [DetBits-1:0]   det;
        logic [DetBits-1:0]   tn;
        coord_t               ax;
        coord_t               ay;
        logic signed [DiffBits-1:0] dx;
        logic signed [DiffBits-1:0] dy;
        coord_t               rx;
        coord_t               ry;
    } job_t;

endpackage

// ===== design/cshs_if.sv =====
// Valid/ready stream channel carrying one word.
interface cshs_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cshs_front.sv =====
// Front end: determinant, line parameters and on-segment classification.
module cshs_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cshs_pkg::cfg_t          cfg,
    input  cshs_pkg::wall_t         wall,
    input  logic                    wall_valid,
    output logic                    wall_ready,
    output cshs_pkg::job_t          job,
    output logic                    job_valid,
    input  logic                    job_ready
);
    localparam int DB = cshs_pkg::DiffBits;
    localparam int PB = cshs_pkg::ProdBits;
    localparam int TB = cshs_pkg::DetBits;

    // stage 1 registers: products
    logic                    s1_valid_reg;
    logic signed [PB-1:0]    p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    cshs_pkg::job_t          s1_job_reg;
    logic [cshs_pkg::IndexBits-1:0] count_reg;

    // stage 2 output register
    logic                    s2_valid_reg;
    cshs_pkg::job_t          s2_job_reg;

    logic advance2, advance1;
    assign advance2   = !s2_valid_reg || job_ready;
    assign advance1   = !s1_valid_reg || advance2;
    assign wall_ready = advance1;
    assign job        = s2_job_reg;
    assign job_valid  = s2_valid_reg;

    logic signed [DB-1:0] a12x, a12y, a13x, a13y, a34x, a34y;
    always_comb
    begin
        a12x = DB'(cfg.look_start_x) - DB'(cfg.look_end_x);
        a12y = DB'(cfg.look_start_y) - DB'(cfg.look_end_y);
        a13x = DB'(cfg.look_start_x) - DB'(wall.wall_start_x);
        a13y = DB'(cfg.look_start_y) - DB'(wall.wall_start_y);
        a34x = DB'(wall.wall_start_x) - DB'(wall.wall_end_x);
        a34y = DB'(wall.wall_start_y) - DB'(wall.wall_end_y);
    end

    // stage 2 combinational: determinant and range test
    logic signed [TB-1:0] d_raw, tn_raw, un_raw, d_abs, tn_abs, un_abs;
    logic hit_c;
    cshs_pkg::job_t s2_job_c;
    always_comb
    begin
        d_raw  = TB'(p1_reg) - TB'(p2_reg);
        tn_raw = TB'(p3_reg) - TB'(p4_reg);
        un_raw = TB'(p5_reg) - TB'(p6_reg);
        if (d_raw < 0)
        begin
            d_abs  = -d_raw;
            tn_abs = -tn_raw;
            un_abs = -un_raw;
        end
        else
        begin
            d_abs  = d_raw;
            tn_abs = tn_raw;
            un_abs = un_raw;
        end
        hit_c = (d_abs != '0) && (tn_abs >= 0) && (tn_abs <= d_abs)
                && (un_abs >= 0) && (un_abs <= d_abs);
        s2_job_c     = s1_job_reg;
        s2_job_c.hit = hit_c;
        s2_job_c.det = d_abs;
        s2_job_c.tn  = tn_abs;
    end

    // pipeline registers and wall counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            if (advance1)
            begin
                s1_valid_reg <= wall_valid;
                if (wall_valid)
                begin
                    if (wall.last_wall)
                        count_reg <= '0;
                    else if (count_reg != cshs_pkg::IndexBits'(cshs_pkg::MaxWalls - 1))
                        count_reg <= count_reg + 1'b1;
                end
            end
            if (advance2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance1 && wall_valid)
        begin
            p1_reg <= a12x * a34y;
            p2_reg <= a12y * a34x;
            p3_reg <= a13x * a34y;
            p4_reg <= a13y * a34x;
            p5_reg <= a12y * a13x;
            p6_reg <= a12x * a13y;
            s1_job_reg.hit  <= 1'b0;
            s1_job_reg.det  <= '0;
            s1_job_reg.tn   <= '0;
            s1_job_reg.last <= wall.last_wall;
            s1_job_reg.pos  <= count_reg;
            s1_job_reg.ax   <= cfg.look_start_x;
            s1_job_reg.ay   <= cfg.look_start_y;
            s1_job_reg.dx   <= -a12x;
            s1_job_reg.dy   <= -a12y;
            s1_job_reg.rx   <= cfg.ref_x;
            s1_job_reg.ry   <= cfg.ref_y;
        end
        if (advance2 && s1_valid_reg)
            s2_job_reg <= s2_job_c;
    end
endmodule

// ===== design/cshs_queue.sv =====
// Short FIFO between front and back ends.
module cshs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  cshs_pkg::job_t in_job,
    input  logic           in_valid,
    output logic           in_ready,
    output cshs_pkg::job_t out_job,
    output logic           out_valid,
    input  logic           out_ready
);
    localparam int PW = cshs_pkg::QPtrBits;

    cshs_pkg::job_t mem_reg [cshs_pkg::QueueDepth];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   cnt_reg;
    logic push, pop;

    assign in_ready  = cnt_reg != (PW+1)'(cshs_pkg::QueueDepth);
    assign out_valid = cnt_reg != '0;
    assign out_job   = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_job;
    end
endmodule

// ===== design/cshs_back.sv =====
// Back end: serial hit point division, distance and nearest-hit tracking.
module cshs_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cshs_pkg::job_t           job,
    input  logic                     job_valid,
    output logic                     job_ready,
    output cshs_pkg::result_t        result,
    output logic                     result_valid,
    input  logic                     result_ready
);
    localparam int TB = cshs_pkg::DetBits;
    localparam int QB = cshs_pkg::QBits;
    localparam int CB = cshs_pkg::CoordBits;
    localparam int XB = CB + 2;
    localparam int SB = 2 * XB;
    localparam int KB = $clog2(QB + 1);

    typedef enum logic [2:0] {S_IDLE, S_DIVX, S_DIVY, S_DIST, S_CMP, S_OUT} state_t;

    state_t state_reg;
    cshs_pkg::job_t job_reg;
    logic [KB-1:0]  bit_reg;
    logic [TB:0]    r_reg;
    logic [QB-1:0]  q_reg;
    logic [QB-1:0]  mag_reg;
    cshs_pkg::coord_t hx_reg, hy_reg;
    logic [SB-1:0]  sqx_reg, sqy_reg;
    logic [cshs_pkg::DistBits-1:0] best_dist_reg;
    logic [cshs_pkg::IndexBits-1:0] best_index_reg;
    cshs_pkg::coord_t best_x_reg, best_y_reg;
    logic any_reg;
    cshs_pkg::result_t result_reg;
    logic result_valid_reg;
    logic out_fire;

    assign job_ready    = (state_reg == S_IDLE);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // a new result loads only when no result is waiting or the waiting one is taken
    assign out_fire = (state_reg == S_OUT) && (!result_valid_reg || result_ready);

    // one restoring step of delta * tn / det
    logic [TB:0] r_a, r_b, r_s;
    logic [QB-1:0] q_a, q_b;
    always_comb
    begin
        r_a = {r_reg[TB-1:0], 1'b0};
        q_a = {q_reg[QB-2:0], 1'b0};
        if (r_a >= {1'b0, job_reg.det})
        begin
            r_a = r_a - {1'b0, job_reg.det};
            q_a = q_a + 1'b1;
        end
        r_b = r_a;
        q_b = q_a;
        if (mag_reg[QB-1])
        begin
            r_b = r_a + {1'b0, job_reg.tn};
            if (r_b >= {1'b0, job_reg.det})
            begin
                r_b = r_b - {1'b0, job_reg.det};
                q_b = q_b + 1'b1;
            end
        end
        r_s = r_b;
    end

    // truncated-toward-zero result of the finished division
    logic signed [XB-1:0] base_c, hit_c, delta_c, a_c;
    logic neg_c;
    always_comb
    begin
        if (state_reg == S_DIVX)
        begin
            a_c     = XB'(job_reg.ax);
            delta_c = XB'(job_reg.dx);
        end
        else
        begin
            a_c     = XB'(job_reg.ay);
            delta_c = XB'(job_reg.dy);
        end
        neg_c = delta_c < 0;
        if (!neg_c)
        begin
            base_c = a_c + $signed({1'b0, q_b[QB-2:0]});
            hit_c  = (r_s != '0 && base_c < 0) ? base_c + 2'sd1 : base_c;
        end
        else
        begin
            base_c = a_c - $signed({1'b0, q_b[QB-2:0]});
            hit_c  = (r_s != '0 && base_c > 0) ? base_c - 2'sd1 : base_c;
        end
    end

    logic [QB-1:0] dy_mag;
    assign dy_mag = job_reg.dy < 0 ? QB'(-job_reg.dy) : QB'(job_reg.dy);

    logic signed [XB-1:0] ex_c, ey_c;
    assign ex_c = XB'(hx_reg) - XB'(job_reg.rx);
    assign ey_c = XB'(hy_reg) - XB'(job_reg.ry);

    logic [cshs_pkg::DistBits-1:0] dist_c;
    assign dist_c = cshs_pkg::DistBits'(sqx_reg + sqy_reg);

    logic [QB-1:0] dx_mag_in;
    assign dx_mag_in = job.dx < 0 ? QB'(-job.dx) : QB'(job.dx);

    // sequencer with scan state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            any_reg          <= 1'b0;
            best_dist_reg    <= '1;
            best_index_reg   <= '0;
            best_x_reg       <= '0;
            best_y_reg       <= '0;
            bit_reg          <= '0;
            r_reg            <= '0;
            q_reg            <= '0;
            mag_reg          <= '0;
            job_reg          <= '0;
            result_reg       <= '0;
            hx_reg           <= '0;
            hy_reg           <= '0;
            sqx_reg          <= '0;
            sqy_reg          <= '0;
        end
        else
        begin
            if (out_fire)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && result_ready)
                result_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid && job_ready)
                    begin
                        job_reg <= job;
                        r_reg   <= '0;
                        q_reg   <= '0;
                        bit_reg <= '0;
                        mag_reg <= dx_mag_in;
                        if (job.hit)
                            state_reg <= S_DIVX;
                        else if (job.last)
                            state_reg <= S_OUT;
                    end
                end
                S_DIVX, S_DIVY:
                begin
                    if (bit_reg == KB'(QB - 1))
                    begin
                        r_reg   <= '0;
                        q_reg   <= '0;
                        bit_reg <= '0;
                        if (state_reg == S_DIVX)
                        begin
                            hx_reg    <= CB'(hit_c);
                            mag_reg   <= dy_mag;
                            state_reg <= S_DIVY;
                        end
                        else
                        begin
                            hy_reg    <= CB'(hit_c);
                            state_reg <= S_DIST;
                        end
                    end
                    else
                    begin
                        r_reg   <= r_s;
                        q_reg   <= q_b;
                        mag_reg <= {mag_reg[QB-2:0], 1'b0};
                        bit_reg <= bit_reg + 1'b1;
                    end
                end
                S_DIST:
                begin
                    sqx_reg   <= SB'(ex_c * ex_c);
                    sqy_reg   <= SB'(ey_c * ey_c);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (!any_reg || dist_c < best_dist_reg)
                    begin
                        best_dist_reg  <= dist_c;
                        best_index_reg <= job_reg.pos;
                        best_x_reg     <= hx_reg;
                        best_y_reg     <= hy_reg;
                        any_reg        <= 1'b1;
                    end
                    state_reg <= job_reg.last ? S_OUT : S_IDLE;
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        result_reg.found     <= any_reg;
                        result_reg.hit_index <= any_reg ? best_index_reg : '0;
                        result_reg.hit_x     <= any_reg ? best_x_reg : '0;
                        result_reg.hit_y     <= any_reg ? best_y_reg : '0;
                        any_reg        <= 1'b0;
                        best_dist_reg  <= '1;
                        best_index_reg <= '0;
                        best_x_reg     <= '0;
                        best_y_reg     <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/closest_segment_hit_scan_core.sv =====
// Top level of the closest segment hit scan block.
// A wall word is accepted whenever the two-stage front pipeline (products, then
// determinant and on-segment test) and the four-entry queue behind it have room.
// In the back end a wall that misses is done in its accept cycle; a wall that
// hits goes on through two serial 18-step divisions that place the hit point,
// then squaring and then compare. The hit rate therefore sets the sustained
// input rate; the queue lets the front keep classifying walls while the back end
// divides. The result is held until taken; meanwhile the back end goes on with
// the next scan's walls and waits only when that scan's result is due. Register
// writes apply to walls accepted afterwards.
module closest_segment_hit_scan_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    cshs_if.sink        wall_in,
    cshs_if.source      result_out
);
    cshs_pkg::cfg_t cfg_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                cshs_pkg::RegLookStartX: cfg_reg.look_start_x <= cfg_data;
                cshs_pkg::RegLookStartY: cfg_reg.look_start_y <= cfg_data;
                cshs_pkg::RegLookEndX:   cfg_reg.look_end_x   <= cfg_data;
                cshs_pkg::RegLookEndY:   cfg_reg.look_end_y   <= cfg_data;
                cshs_pkg::RegRefX:       cfg_reg.ref_x        <= cfg_data;
                cshs_pkg::RegRefY:       cfg_reg.ref_y        <= cfg_data;
                default: ;
            endcase
        end
    end

    cshs_pkg::job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;

    cshs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .wall       (wall_in.data),
        .wall_valid (wall_in.valid),
        .wall_ready (wall_in.ready),
        .job        (f_job),
        .job_valid  (f_valid),
        .job_ready  (f_ready)
    );

    cshs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_job    (f_job),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .out_job   (q_job),
        .out_valid (q_valid),
        .out_ready (q_ready)
    );

    cshs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (q_job),
        .job_valid    (q_valid),
        .job_ready    (q_ready),
        .result       (result_out.data),
        .result_valid (result_out.valid),
        .result_ready (result_out.ready)
    );

    // a reported miss carries zero fields; the index and x fields are checked
    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && !result_out.data.found |->
            result_out.data.hit_index == '0 && result_out.data.hit_x == '0)
        else $error("miss result with nonzero fields");

    // a front word stalled by a full queue holds until the queue takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |=> f_valid && $stable(f_job))
        else $error("front word changed while stalled");

    // a waiting result word holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && !result_out.ready |=>
            result_out.valid && $stable(result_out.data))
        else $error("result word changed while waiting");
endmodule

// ===== sim/tb_closest_segment_hit_scan_core.sv =====
// Self-checking testbench for the closest segment hit scan core.
module tb_closest_segment_hit_scan_core;

    localparam logic [2:0] RegUnused6 = 3'd6;
    localparam logic [2:0] RegUnused7 = 3'd7;
    localparam longint DistAllOnes = (64'd1 << cshs_pkg::DistBits) - 1;
    localparam int DrainCycles = 80;
    localparam int StallLimit = 3000;
    localparam int LongHold = 300;
    localparam int LongScanWalls = 1030;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    cshs_if #(.word_t(cshs_pkg::wall_t))   wall_ch ();
    cshs_if #(.word_t(cshs_pkg::result_t)) result_ch ();

    closest_segment_hit_scan_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .wall_in    (wall_ch.sink),
        .result_out (result_ch.source)
    );

    // Predictor state: register copy plus running nearest hit
    cshs_pkg::cfg_t   settings;
    longint           best_dist;
    logic [cshs_pkg::IndexBits-1:0] best_pos;
    cshs_pkg::coord_t best_x;
    cshs_pkg::coord_t best_y;
    bit               seen_hit;
    logic [cshs_pkg::IndexBits-1:0] wall_pos;

    cshs_pkg::result_t expected_results[$];
    int      errors;
    int      quiet_cycles;
    bit      hold_req;
    bit      send_idle_on;
    bit      recv_idle_on;

    // Directed rows
    typedef struct {
        cshs_pkg::wall_t   w;
        bit                typed;
        cshs_pkg::result_t r;
    } row_t;

    row_t rows[$];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Exact a + delta*tn/d, truncated toward zero
    function automatic longint lerp_toward_zero(longint a, longint delta, longint tn, longint d);
        longint mag;
        longint q;
        longint rm;
        longint base;
        mag = (delta < 0) ? -delta : delta;
        q = (mag * tn) / d;
        rm = (mag * tn) % d;
        if (delta >= 0)
        begin
            base = a + q;
            return (rm != 0 && base < 0) ? base + 1 : base;
        end
        base = a - q;
        return (rm != 0 && base > 0) ? base - 1 : base;
    endfunction

    // Advance the nearest-hit scan by one wall; returns 1 when a result is due
    function automatic bit scan_wall(cshs_pkg::wall_t w, output cshs_pkg::result_t r);
        longint x1, y1, x2, y2, rx, ry, x3, y3, x4, y4;
        longint d, tn, un, hx, hy, ex, ey, dist_sq;
        x1 = settings.look_start_x; y1 = settings.look_start_y;
        x2 = settings.look_end_x;   y2 = settings.look_end_y;
        rx = settings.ref_x;        ry = settings.ref_y;
        x3 = w.wall_start_x; y3 = w.wall_start_y;
        x4 = w.wall_end_x;   y4 = w.wall_end_y;
        d  = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
        tn = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
        un = (y1 - y2) * (x1 - x3) - (x1 - x2) * (y1 - y3);
        if (d < 0)
        begin
            d = -d; tn = -tn; un = -un;
        end
        if (d != 0 && tn >= 0 && tn <= d && un >= 0 && un <= d)
        begin
            hx = lerp_toward_zero(x1, x2 - x1, tn, d);
            hy = lerp_toward_zero(y1, y2 - y1, tn, d);
            ex = hx - rx;
            ey = hy - ry;
            dist_sq = ex * ex + ey * ey;
            if (!seen_hit || dist_sq < best_dist)
            begin
                best_dist = dist_sq;
                best_pos = wall_pos;
                best_x = cshs_pkg::coord_t'(hx);
                best_y = cshs_pkg::coord_t'(hy);
                seen_hit = 1'b1;
            end
        end
        if (wall_pos < cshs_pkg::MaxWalls - 1)
            wall_pos++;
        r = '0;
        if (!w.last_wall)
            return 1'b0;
        if (seen_hit)
        begin
            r.found = 1'b1;
            r.hit_index = best_pos;
            r.hit_x = best_x;
            r.hit_y = best_y;
        end
        best_dist = DistAllOnes;
        best_pos = '0;
        best_x = '0;
        best_y = '0;
        seen_hit = 1'b0;
        wall_pos = '0;
        return 1'b1;
    endfunction

    function automatic cshs_pkg::coord_t clamp16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return cshs_pkg::coord_t'(v);
    endfunction

    // Mostly walls crossing the look segment; the rest random or full-range noise
    function automatic cshs_pkg::wall_t make_wall(bit last);
        cshs_pkg::wall_t w;
        int px, py, vx, vy, k, j, pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            w = cshs_pkg::wall_t'({$urandom, $urandom, 1'b0});
        end
        else if (pick < 30)
        begin
            w.wall_start_x = clamp16(int'(settings.look_start_x)
                                     + $signed($urandom_range(0, 800)) - 400);
            w.wall_start_y = clamp16(int'(settings.look_start_y)
                                     + $signed($urandom_range(0, 800)) - 400);
            w.wall_end_x   = clamp16(int'(settings.look_end_x)
                                     + $signed($urandom_range(0, 800)) - 400);
            w.wall_end_y   = clamp16(int'(settings.look_end_y)
                                     + $signed($urandom_range(0, 800)) - 400);
        end
        else
        begin
            k = $urandom_range(0, 64);
            px = int'(settings.look_start_x)
                 + (int'(settings.look_end_x) - int'(settings.look_start_x)) * k / 64;
            py = int'(settings.look_start_y)
                 + (int'(settings.look_end_y) - int'(settings.look_start_y)) * k / 64;
            vx = int'($urandom_range(0, 600)) - 300;
            vy = int'($urandom_range(0, 600)) - 300;
            j = $urandom_range(1, 8);
            w.wall_start_x = clamp16(px + vx);
            w.wall_start_y = clamp16(py + vy);
            w.wall_end_x   = clamp16(px - vx * j / 4);
            w.wall_end_y   = clamp16(py - vy * j / 4);
        end
        w.last_wall = last;
        return w;
    endfunction

    function automatic int draw_gap(bit idle_on);
        return idle_on ? $urandom_range(0, 11) : 0;
    endfunction

    // Write all registers at idle, plus the two unused indexes
    task automatic load_settings(cshs_pkg::cfg_t s);
        logic [15:0] vals[6];
        vals[0] = s.look_start_x; vals[1] = s.look_start_y;
        vals[2] = s.look_end_x;   vals[3] = s.look_end_y;
        vals[4] = s.ref_x;        vals[5] = s.ref_y;
        for (int i = 0; i < 6; i++)
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= (i == 0) ? cshs_pkg::RegLookStartX :
                         (i == 1) ? cshs_pkg::RegLookStartY :
                         (i == 2) ? cshs_pkg::RegLookEndX :
                         (i == 3) ? cshs_pkg::RegLookEndY :
                         (i == 4) ? cshs_pkg::RegRefX : cshs_pkg::RegRefY;
            cfg_data <= vals[i];
        end
        @(negedge clk);
        cfg_index <= RegUnused6;
        cfg_data <= $urandom;
        @(negedge clk);
        cfg_index <= RegUnused7;
        cfg_data <= $urandom;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings = s;
    endtask

    // Stop offering walls, then wait for every due result and a quiet tail
    task automatic wait_idle();
        @(negedge clk);
        wall_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Offer one wall word; returns at the accepting edge
    task automatic send_wall(cshs_pkg::wall_t w, bit typed, cshs_pkg::result_t typed_r);
        int gap;
        cshs_pkg::result_t r;
        @(negedge clk);
        gap = draw_gap(send_idle_on);
        if (gap > 0)
        begin
            wall_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        wall_ch.valid <= 1'b1;
        wall_ch.data <= w;
        do
            @(posedge clk);
        while (!wall_ch.ready);
        if (scan_wall(w, r))
            expected_results = {expected_results, (typed ? typed_r : r)};
    endtask

    task automatic send_random_scan(int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                send_idle_on = ~send_idle_on;
            send_wall(make_wall(i == len - 1), 1'b0, '0);
        end
    endtask

    function automatic row_t mk_row(int sx, int sy, int ex, int ey, bit last,
                                    bit typed, bit f, int idx, int hx, int hy);
        row_t rw;
        rw.w = '{cshs_pkg::coord_t'(sx), cshs_pkg::coord_t'(sy),
                 cshs_pkg::coord_t'(ex), cshs_pkg::coord_t'(ey), last};
        rw.typed = typed;
        rw.r = '{f, cshs_pkg::IndexBits'(idx), cshs_pkg::coord_t'(hx),
                 cshs_pkg::coord_t'(hy)};
        return rw;
    endfunction

    // Receiver: random holds, one long hold on request
    initial
    begin
        int gap;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
                recv_idle_on = ~recv_idle_on;
            gap = draw_gap(recv_idle_on);
            if (hold_req)
            begin
                gap = LongHold;
                hold_req = 1'b0;
            end
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
        end
    end

    // Result checker and stall watchdog
    always @(posedge clk)
    begin
        cshs_pkg::result_t got;
        cshs_pkg::result_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.found !== want.found)
                begin
                    $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
                    errors++;
                end
                if (got.hit_index !== want.hit_index)
                begin
                    $display("%0t: hit_index exp %0d got %0d", $time,
                             want.hit_index, got.hit_index);
                    errors++;
                end
                if (got.hit_x !== want.hit_x)
                begin
                    $display("%0t: hit_x exp %0d got %0d", $time, want.hit_x, got.hit_x);
                    errors++;
                end
                if (got.hit_y !== want.hit_y)
                begin
                    $display("%0t: hit_y exp %0d got %0d", $time, want.hit_y, got.hit_y);
                    errors++;
                end
            end
        end
        if ((result_ch.valid && result_ch.ready) || (wall_ch.valid && wall_ch.ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        cshs_pkg::cfg_t s;
        errors = 0;
        quiet_cycles = 0;
        hold_req = 1'b0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = cshs_pkg::RegLookStartX;
        cfg_data = '0;
        wall_ch.valid = 1'b0;
        wall_ch.data = '0;
        settings = '0;
        best_dist = DistAllOnes;
        best_pos = '0;
        best_x = '0;
        best_y = '0;
        seen_hit = 1'b0;
        wall_pos = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset registers are zero: a zero-length look segment never hits
        rows = {rows, mk_row(-16, -16, 16, 16, 1, 1, 0, 0, 0, 0)};
        foreach (rows[i])
            send_wall(rows[i].w, rows[i].typed, rows[i].r);
        rows.delete();
        wait_idle();

        // Look along +x from origin, ranked from origin
        load_settings('{16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0, 16'sd0});
        rows = {rows, mk_row(80, -16, 80, 16, 1, 1, 1, 0, 80, 0)};
        rows = {rows, mk_row(0, 16, 160, 16, 1, 1, 0, 0, 0, 0)};
        rows = {rows, mk_row(80, 0, 80, 0, 1, 1, 0, 0, 0, 0)};
        rows = {rows, mk_row(120, -16, 120, 16, 0, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(40, -16, 40, 16, 1, 1, 1, 1, 40, 0)};
        rows = {rows, mk_row(40, -16, 40, 16, 0, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(40, 16, 40, -16, 1, 1, 1, 0, 40, 0)};
        rows = {rows, mk_row(160, -16, 160, 16, 1, 1, 1, 0, 160, 0)};
        rows = {rows, mk_row(200, -16, 200, 16, 0, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(0, -16, 0, 16, 1, 1, 1, 1, 0, 0)};
        rows = {rows, mk_row(-32768, -32768, 32767, 32767, 1, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(-32768, 32767, 32767, -32768, 1, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(32767, 32767, 32767, -32768, 1, 1, 0, 0, 0, 0)};
        rows = {rows, mk_row(50, -32768, 70, 32767, 1, 0, 0, 0, 0, 0)};
        foreach (rows[i])
            send_wall(rows[i].w, rows[i].typed, rows[i].r);
        wait_idle();

        // Extreme look segment corner to corner
        load_settings('{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                        16'sd32767, -16'sd32768});
        send_random_scan(6);
        send_random_scan(6);
        wait_idle();

        // Random phases, each reloading the settings first
        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph % 4)
                0: s = '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                         -16'sd32768, -16'sd32768};
                1: s = cshs_pkg::cfg_t'({$urandom, $urandom, $urandom});
                default:
                    s = '{cshs_pkg::coord_t'($urandom_range(0, 4000) - 2000),
                          cshs_pkg::coord_t'($urandom_range(0, 4000) - 2000),
                          cshs_pkg::coord_t'($urandom_range(0, 4000) - 2000),
                          cshs_pkg::coord_t'($urandom_range(0, 4000) - 2000),
                          cshs_pkg::coord_t'($urandom_range(0, 4000) - 2000),
                          cshs_pkg::coord_t'($urandom_range(0, 4000) - 2000)};
            endcase
            load_settings(s);
            if (ph == 3)
                hold_req = 1'b1;
            if (ph == 5)
                send_random_scan(LongScanWalls);
            for (int n = 0; n < 5; n++)
                send_random_scan($urandom_range(1, 8));
            wait_idle();
        end

        @(negedge clk);
        wall_ch.valid <= 1'b0;
        wait_idle();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
